@@ rtl/timed_access_watchdog_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Timed-access watchdog unit: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TIMED_ACCESS_WATCHDOG_UNIT_DEFINES_SVH
`define TIMED_ACCESS_WATCHDOG_UNIT_DEFINES_SVH

// Same-cycle implication.
`define TAWD_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tawd: same-cycle check failed");

// Next-cycle implication.
`define TAWD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tawd: next-cycle check failed");

`endif

@@ rtl/tawd_pkg.sv @@
// ----------------------------------------------------------------------------
// tawd_pkg
// Types and constants shared by the timed-access watchdog unit.
// ----------------------------------------------------------------------------
package tawd_pkg;

	localparam int TIME_W     = 48;
	localparam int FREQ_W     = 25;
	localparam int WIN_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 25;
	localparam int IVL_W      = 46;

	// Shared divider: the dividend covers the largest count times one million.
	localparam int DIV_N_W   = IVL_W;
	localparam int DIV_D_W   = FREQ_W;
	localparam int DIV_STEPS = DIV_N_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_OSC_FREQ    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WDT_PRESENT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_WIN  = 2'd2;

	localparam longint unsigned OSC_RST_HZ = 64'd24000000;
	localparam longint unsigned US_PER_S   = 64'd1000000;
	localparam longint unsigned BASE_COUNT = 64'd131072;

	localparam logic [FREQ_W-1:0] OSC_RST = FREQ_W'(OSC_RST_HZ);
	localparam logic [WIN_W-1:0]  WIN_RST = 16'd100;
	localparam logic [IVL_W-1:0]  IVL_RST = IVL_W'(BASE_COUNT * US_PER_S / OSC_RST_HZ);
	localparam logic [19:0]       MILLION = 20'd1000000;

	typedef struct packed {
		logic              func;
		logic [7:0]        reg_addr;
		logic [7:0]        write_data;
		logic [TIME_W-1:0] now_us;
	} tawd_in_t;

	typedef struct packed {
		logic              write_taken;
		logic [1:0]        unlock_state;
		logic              overflow_now;
		logic [31:0]       overflow_count;
		logic [TIME_W-1:0] next_deadline_us;
		logic [FREQ_W-1:0] sys_clock_hz;
	} tawd_out_t;

	typedef struct packed {
		logic item_load;
		logic exec;
		logic cfg_write;
		logic div_start;
		logic div_is_ivl;
		logic clk_capture;
		logic ivl_capture;
		logic out_load;
	} tawd_cmd_t;

	typedef struct packed {
		logic need_clk_cfg;
		logic need_clk;
		logic need_ivl;
		logic div_done;
	} tawd_sts_t;

	// Watchdog counts are powers of two, so count * 1e6 is a shift of 1e6.
	function automatic logic [4:0] wd_shift(input logic [2:0] sel);
		logic [4:0] sh;
		case (sel)
			3'd0:    sh = 5'd17;
			3'd1:    sh = 5'd18;
			3'd2:    sh = 5'd19;
			3'd3:    sh = 5'd20;
			3'd4:    sh = 5'd21;
			3'd5:    sh = 5'd22;
			3'd6:    sh = 5'd24;
			3'd7:    sh = 5'd26;
			default: sh = 5'd17;
		endcase
		return sh;
	endfunction

endpackage

@@ rtl/tawd_div.sv @@
// ----------------------------------------------------------------------------
// tawd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tawd_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [tawd_pkg::DIV_N_W-1:0] dividend,
	input  logic [tawd_pkg::DIV_D_W-1:0] divisor,
	output logic                         done,
	output logic [tawd_pkg::DIV_N_W-1:0] quotient
);
	import tawd_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_N_W-1:0]   dvd_q;
	logic [DIV_D_W-1:0]   dvs_q;
	logic [DIV_D_W-1:0]   rem_q;
	logic [DIV_D_W:0]     shifted;
	logic                 fits;

	assign shifted = {rem_q, dvd_q[DIV_N_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_N_W-2:0], fits};
			rem_q <= fits ? DIV_D_W'(shifted - {1'b0, dvs_q}) : shifted[DIV_D_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

@@ rtl/tawd_dp.sv @@
// ----------------------------------------------------------------------------
// tawd_dp
// Datapath: unlock sequence, watchdog state, clock and interval registers.
// ----------------------------------------------------------------------------
`include "timed_access_watchdog_unit_defines.svh"

module tawd_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tawd_pkg::tawd_cmd_t             cmd,
	output tawd_pkg::tawd_sts_t             sts,
	input  tawd_pkg::tawd_in_t              in_data,
	input  logic [tawd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tawd_pkg::CFG_DATA_W-1:0] cfg_data,
	output tawd_pkg::tawd_out_t             out_data
);
	import tawd_pkg::*;

	localparam logic [7:0] ADDR_TA     = 8'h96;
	localparam logic [7:0] ADDR_CLKDIV = 8'h8F;
	localparam logic [7:0] ADDR_WDCON  = 8'h97;
	localparam logic [7:0] ADDR_CKCON  = 8'h8E;
	localparam logic [7:0] KEY_FIRST   = 8'hAA;
	localparam logic [7:0] KEY_SECOND  = 8'h55;
	localparam int         WD_ARM_BIT  = 1;
	localparam int         WD_FEED_BIT = 0;
	localparam logic       FUNC_WRITE  = 1'b0;

	localparam logic [1:0] PH_LOCKED = 2'd0;
	localparam logic [1:0] PH_KEY1   = 2'd1;
	localparam logic [1:0] PH_OPEN   = 2'd2;

	// Configuration registers.
	logic [FREQ_W-1:0] osc_q;
	logic              wdt_q;
	logic [WIN_W-1:0]  win_q;

	// Architectural state.
	logic [1:0]        phase_q, phase_d;
	logic [TIME_W-1:0] key1_q, key1_d;
	logic [TIME_W-1:0] feed_q, feed_d;
	logic              latched_q, latched_d;
	logic [7:0]        wdcon_q, wdcon_d;
	logic [7:0]        clkdiv_q, clkdiv_d;
	logic [2:0]        sel_q, sel_d;
	logic [31:0]       total_q, total_d;
	logic [FREQ_W-1:0] clock_q;
	logic [IVL_W-1:0]  ivl_q;

	// Item being worked on and its per-item flags.
	tawd_in_t          item_q;
	logic              taken_q, taken_d;
	logic              fired_q, fired_d;
	tawd_out_t         res_q;

	logic              prot;
	logic [1:0]        p1, p2;
	logic [TIME_W-1:0] key_gap;
	logic [TIME_W-1:0] since_feed;
	logic [IVL_W-1:0]  ivl_eff;
	logic              wd_active;
	logic [DIV_N_W-1:0] div_n;
	logic [DIV_D_W-1:0] div_d;
	logic               div_done;
	logic [DIV_N_W-1:0] div_q;
	logic [TIME_W-1:0]  deadline;

	assign ivl_eff    = wdt_q ? ivl_q : '0;
	assign wd_active  = wdt_q && wdcon_q[WD_ARM_BIT] && !latched_q;
	assign key_gap    = item_q.now_us - key1_q;
	assign since_feed = item_q.now_us - feed_q;

	always_comb begin
		phase_d   = phase_q;
		key1_d    = key1_q;
		feed_d    = feed_q;
		latched_d = latched_q;
		wdcon_d   = wdcon_q;
		clkdiv_d  = clkdiv_q;
		sel_d     = sel_q;
		total_d   = total_q;
		taken_d   = 1'b1;
		fired_d   = 1'b0;
		prot      = (item_q.reg_addr inside {ADDR_TA, ADDR_CLKDIV, ADDR_WDCON});
		p1        = (wdt_q && !prot) ? PH_LOCKED : phase_q;
		p2        = (p1 == PH_KEY1 && key_gap > TIME_W'(win_q)) ? PH_LOCKED : p1;
		if (item_q.func == FUNC_WRITE) begin
			if (item_q.reg_addr == ADDR_TA) begin
				if (p2 == PH_LOCKED && item_q.write_data == KEY_FIRST) begin
					phase_d = PH_KEY1;
					key1_d  = item_q.now_us;
				end else if (p2 == PH_KEY1 && item_q.write_data == KEY_SECOND) begin
					phase_d = PH_OPEN;
				end else begin
					phase_d = PH_LOCKED;
				end
			end else if (item_q.reg_addr == ADDR_CLKDIV || item_q.reg_addr == ADDR_WDCON) begin
				// Any protected write uses up the unlock, whether taken or not.
				phase_d = PH_LOCKED;
				if (p1 != PH_OPEN) begin
					taken_d = 1'b0;
				end else if (item_q.reg_addr == ADDR_CLKDIV) begin
					clkdiv_d = item_q.write_data;
				end else begin
					wdcon_d = item_q.write_data;
					if ((!wdcon_q[WD_ARM_BIT] && item_q.write_data[WD_ARM_BIT])
							|| item_q.write_data[WD_FEED_BIT]) begin
						feed_d    = item_q.now_us;
						latched_d = 1'b0;
					end
				end
			end else if (item_q.reg_addr == ADDR_CKCON) begin
				sel_d   = item_q.write_data[7:5];
				phase_d = p1;
			end else begin
				phase_d = p1;
			end
		end else if (wd_active && ivl_eff != '0 && item_q.now_us >= feed_q
				&& since_feed >= TIME_W'(ivl_eff)) begin
			latched_d = 1'b1;
			fired_d   = 1'b1;
			if (!(&total_q)) begin
				total_d = total_q + 32'd1;
			end
		end
	end

	assign sts.need_clk_cfg = (cfg_index == CFG_OSC_FREQ);
	assign sts.need_clk     = (item_q.func == FUNC_WRITE) && (item_q.reg_addr == ADDR_CLKDIV)
		&& (phase_q == PH_OPEN);
	assign sts.need_ivl     = (item_q.func == FUNC_WRITE) && (item_q.reg_addr == ADDR_CKCON);
	assign sts.div_done     = div_done;

	// Clock derivation divides fosc by 2*div; the interval divides count*1e6 by fsys.
	assign div_n = cmd.div_is_ivl ? (DIV_N_W'(MILLION) << wd_shift(sel_q))
		: DIV_N_W'(osc_q);
	assign div_d = cmd.div_is_ivl ? clock_q : DIV_D_W'({clkdiv_q, 1'b0});

	tawd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			osc_q     <= OSC_RST;
			wdt_q     <= 1'b1;
			win_q     <= WIN_RST;
			phase_q   <= PH_LOCKED;
			key1_q    <= '0;
			feed_q    <= '0;
			latched_q <= 1'b0;
			wdcon_q   <= '0;
			clkdiv_q  <= '0;
			sel_q     <= '0;
			total_q   <= '0;
			clock_q   <= OSC_RST;
			ivl_q     <= IVL_RST;
		end else begin
			if (cmd.cfg_write) begin
				case (cfg_index)
					CFG_OSC_FREQ:    osc_q <= cfg_data;
					CFG_WDT_PRESENT: wdt_q <= cfg_data[0];
					CFG_UNLOCK_WIN:  win_q <= cfg_data[WIN_W-1:0];
					default:         ;
				endcase
			end
			if (cmd.exec) begin
				phase_q   <= phase_d;
				key1_q    <= key1_d;
				feed_q    <= feed_d;
				latched_q <= latched_d;
				wdcon_q   <= wdcon_d;
				clkdiv_q  <= clkdiv_d;
				sel_q     <= sel_d;
				total_q   <= total_d;
			end
			if (cmd.clk_capture) begin
				// A divided clock of zero falls back to the oscillator.
				clock_q <= (clkdiv_q == '0 || div_q == '0) ? osc_q : div_q[FREQ_W-1:0];
			end
			if (cmd.ivl_capture) begin
				ivl_q <= (clock_q == '0) ? '0 : div_q;
			end
		end
	end

	assign deadline = (wd_active && ivl_eff != '0) ? feed_q + TIME_W'(ivl_eff) : '1;

	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			item_q <= in_data;
		end
		if (cmd.exec) begin
			taken_q <= taken_d;
			fired_q <= fired_d;
		end
		if (cmd.out_load) begin
			res_q.write_taken      <= taken_q;
			res_q.unlock_state     <= phase_q;
			res_q.overflow_now     <= fired_q;
			res_q.overflow_count   <= total_q;
			res_q.next_deadline_us <= deadline;
			res_q.sys_clock_hz     <= clock_q;
		end
	end

	assign out_data = res_q;

	`TAWD_ASSERT_NEXT(ovf_total_monotonic, 1'b1, total_q >= $past(total_q))
	`TAWD_ASSERT_IMPL(ovf_latch_counts, $rose(latched_q), total_q == $past(total_q) + 32'd1 || &total_q)

endmodule

@@ rtl/tawd_ctrl.sv @@
// ----------------------------------------------------------------------------
// tawd_ctrl
// Controller: sequences item execution, divider runs and result hand-off.
// ----------------------------------------------------------------------------
`include "timed_access_watchdog_unit_defines.svh"

module tawd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  tawd_pkg::tawd_sts_t sts,
	output tawd_pkg::tawd_cmd_t cmd
);
	import tawd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CLK_GO,
		ST_CLK_WAIT,
		ST_IVL_GO,
		ST_IVL_WAIT,
		ST_DONE
	} state_t;

	state_t state_q, state_d;
	logic   item_q, item_d;
	logic   out_valid_q;

	always_comb begin
		state_d   = state_q;
		item_d    = item_q;
		cmd       = '0;
		in_ready  = 1'b0;
		cfg_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cfg_ready = 1'b1;
				in_ready  = !cfg_valid;
				if (cfg_valid) begin
					cmd.cfg_write = 1'b1;
					if (sts.need_clk_cfg) begin
						item_d  = 1'b0;
						state_d = ST_CLK_GO;
					end
				end else if (in_valid) begin
					cmd.item_load = 1'b1;
					item_d        = 1'b1;
					state_d       = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (sts.need_clk) begin
					state_d = ST_CLK_GO;
				end else if (sts.need_ivl) begin
					state_d = ST_IVL_GO;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_CLK_GO: begin
				cmd.div_start = 1'b1;
				state_d       = ST_CLK_WAIT;
			end
			ST_CLK_WAIT: begin
				if (sts.div_done) begin
					cmd.clk_capture = 1'b1;
					state_d         = ST_IVL_GO;
				end
			end
			ST_IVL_GO: begin
				cmd.div_start  = 1'b1;
				cmd.div_is_ivl = 1'b1;
				state_d        = ST_IVL_WAIT;
			end
			ST_IVL_WAIT: begin
				cmd.div_is_ivl = 1'b1;
				if (sts.div_done) begin
					cmd.ivl_capture = 1'b1;
					state_d         = item_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			item_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			item_q      <= item_d;
			out_valid_q <= cmd.out_load || (out_valid_q && !out_ready);
		end
	end

	assign out_valid = out_valid_q;

	`TAWD_ASSERT_NEXT(accept_goes_busy, in_valid && in_ready, !in_ready && !cfg_ready)
	`TAWD_ASSERT_IMPL(load_only_when_free, cmd.out_load, !out_valid_q || out_ready)

endmodule

@@ rtl/timed_access_watchdog_unit.sv @@
// ----------------------------------------------------------------------------
// timed_access_watchdog_unit
// Timed-access protected watchdog: unlock keys, protected register writes,
// system clock derivation and watchdog overflow detection on polls.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// in        in         in_valid / in_ready    in_data   (tawd_in_t)
// out       out        out_valid / out_ready  out_data  (tawd_out_t)
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A plain item runs through the execute and done states, where the output register loads;
// only then is the next item taken. A taken CLKDIV write or an oscillator frequency write
// adds two runs of the shared divider (clock, then interval); a CKCON write adds one run.
// Reset is asynchronous and active low; all state but the item, result and divider data
// registers takes its reset value at once. A held result lets the next item execute,
// which then waits for the output register.
// ----------------------------------------------------------------------------
module timed_access_watchdog_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  tawd_pkg::tawd_in_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output tawd_pkg::tawd_out_t             out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tawd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tawd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tawd_pkg::*;

	// The controller never touches payload; it only issues commands to the
	// datapath and watches the few status flags that steer its sequence.
	tawd_cmd_t cmd;
	tawd_sts_t sts;

	tawd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the unlock phase, the watchdog registers, the derived
	// clock and interval, the divider, and the output register.
	tawd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (out_data)
	);

endmodule

@@ bench/tb_timed_access_watchdog_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timed_access_watchdog_unit
// Self-checking bench for the timed-access watchdog unit. A cycle-free model
// of the unlock sequence, the protected registers, the clock divider and the
// watchdog predicts one result per accepted item; every result is compared
// field by field in order. Directed cases come first, then random traffic
// under several idle and stall patterns and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_timed_access_watchdog_unit;
	import tawd_pkg::*;

	// Register addresses, unlock keys and WDCON bits of the protected unit.
	localparam logic [7:0] ADDR_TA     = 8'h96;
	localparam logic [7:0] ADDR_CLKDIV = 8'h8F;
	localparam logic [7:0] ADDR_WDCON  = 8'h97;
	localparam logic [7:0] ADDR_CKCON  = 8'h8E;
	localparam logic [7:0] KEY_FIRST   = 8'hAA;
	localparam logic [7:0] KEY_SECOND  = 8'h55;
	localparam logic [7:0] WDCON_ARM   = 8'h02;
	localparam logic [7:0] WDCON_FEED  = 8'h01;
	localparam logic [7:0] CKCON_SEL7  = 8'hE0;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_POLL  = 1'b1;

	localparam logic [1:0] TA_LOCKED = 2'd0;
	localparam logic [1:0] TA_KEY1   = 2'd1;
	localparam logic [1:0] TA_OPEN   = 2'd2;

	localparam logic [TIME_W-1:0] TIME_TOP    = '1;
	localparam logic [TIME_W-1:0] NO_DEADLINE = '1;
	localparam logic [FREQ_W-1:0] OSC_MAX     = '1;

	// An oscillator write runs the divider twice with no result to show for it, so
	// register writes wait SETTLE_CYCLES once the block has drained.
	localparam int SETTLE_CYCLES = 200;
	localparam int HOLD_CYCLES   = 400;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	tawd_in_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	tawd_out_t             out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	timed_access_watchdog_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------------
	// Watchdog model state. Configuration first, then the block's own state.
	// ------------------------------------------------------------------------
	logic [FREQ_W-1:0] osc_hz;
	logic              wdt_en;
	logic [WIN_W-1:0]  win_us;

	logic [1:0]        key_phase;
	logic [TIME_W-1:0] key1_us;
	logic [TIME_W-1:0] feed_us;
	logic              ovf_latched;
	logic [7:0]        wdcon_q;
	logic [7:0]        clkdiv_q;
	logic [2:0]        scale_sel;
	logic [31:0]       ovf_total;
	logic [FREQ_W-1:0] sys_hz;

	// Watchdog counts selected by CKCON bits 7..5.
	longint unsigned wd_counts [8] = '{
		64'd131072, 64'd262144, 64'd524288, 64'd1048576,
		64'd2097152, 64'd4194304, 64'd16777216, 64'd67108864
	};

	tawd_out_t         expected_results [$];
	int                error_count;
	int                send_idle_pct;
	int                recv_stall_pct;
	bit                hold_req;
	int                hold_left;
	logic [TIME_W-1:0] now_us;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard limit: far beyond the slowest legal run of all phases.
	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Model functions
	// ------------------------------------------------------------------------
	function automatic logic [FREQ_W-1:0] divided_clock();
		longint unsigned f;
		f = osc_hz;
		if (clkdiv_q != 8'd0) begin
			f = osc_hz / (2 * clkdiv_q);
			// A divided clock of zero falls back to the oscillator.
			if (f == 0)
				f = osc_hz;
		end
		return f[FREQ_W-1:0];
	endfunction

	function automatic longint unsigned wd_interval();
		if (!wdt_en || sys_hz == '0)
			return 0;
		return wd_counts[scale_sel] * US_PER_S / sys_hz;
	endfunction

	function automatic logic wd_armed();
		return wdt_en && (wdcon_q & WDCON_ARM) != 8'd0 && !ovf_latched;
	endfunction

	function automatic void reset_watchdog_model();
		osc_hz      = OSC_RST;
		wdt_en      = 1'b1;
		win_us      = WIN_RST;
		key_phase   = TA_LOCKED;
		key1_us     = '0;
		feed_us     = '0;
		ovf_latched = 1'b0;
		wdcon_q     = '0;
		clkdiv_q    = '0;
		scale_sel   = '0;
		ovf_total   = '0;
		sys_hz      = OSC_RST;
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_OSC_FREQ: begin
				// The system clock follows the new oscillator at once.
				osc_hz = val[FREQ_W-1:0];
				sys_hz = divided_clock();
			end
			CFG_WDT_PRESENT: wdt_en = val[0];
			CFG_UNLOCK_WIN:  win_us = val[WIN_W-1:0];
			default: ;
		endcase
	endfunction

	// Advances the model by one item and returns the result it must produce.
	function automatic tawd_out_t predict_watchdog(input tawd_in_t it);
		tawd_out_t         r;
		longint unsigned   ivl;
		logic [TIME_W-1:0] key_gap;
		logic              is_prot;
		logic              unlocked;
		logic              was_armed;

		r.write_taken  = 1'b1;
		r.overflow_now = 1'b0;
		if (it.func == FUNC_WRITE) begin
			is_prot = it.reg_addr == ADDR_TA || it.reg_addr == ADDR_CLKDIV ||
				it.reg_addr == ADDR_WDCON;
			// Any unprotected write aborts a pending unlock when the part has
			// the watchdog.
			if (wdt_en && !is_prot)
				key_phase = TA_LOCKED;
			if (it.reg_addr == ADDR_TA) begin
				// The window is measured modulo the time width, so a time
				// that went backwards looks like a huge gap.
				key_gap = it.now_us - key1_us;
				if (key_phase == TA_KEY1 && key_gap > win_us)
					key_phase = TA_LOCKED;
				if (key_phase == TA_LOCKED && it.write_data == KEY_FIRST) begin
					key_phase = TA_KEY1;
					key1_us   = it.now_us;
				end else if (key_phase == TA_KEY1 && it.write_data == KEY_SECOND) begin
					key_phase = TA_OPEN;
				end else begin
					key_phase = TA_LOCKED;
				end
			end else if (it.reg_addr == ADDR_CLKDIV || it.reg_addr == ADDR_WDCON) begin
				// A protected write uses up the unlock whether taken or not.
				unlocked  = key_phase == TA_OPEN;
				key_phase = TA_LOCKED;
				if (!unlocked) begin
					r.write_taken = 1'b0;
				end else if (it.reg_addr == ADDR_CLKDIV) begin
					clkdiv_q = it.write_data;
					sys_hz   = divided_clock();
				end else begin
					was_armed = (wdcon_q & WDCON_ARM) != 8'd0;
					wdcon_q   = it.write_data;
					if ((!was_armed && (it.write_data & WDCON_ARM) != 8'd0) ||
							(it.write_data & WDCON_FEED) != 8'd0) begin
						feed_us     = it.now_us;
						ovf_latched = 1'b0;
					end
				end
			end else if (it.reg_addr == ADDR_CKCON) begin
				scale_sel = it.write_data[7:5];
			end
		end else if (wd_armed()) begin
			ivl = wd_interval();
			if (ivl != 0 && it.now_us >= feed_us && it.now_us - feed_us >= ivl) begin
				ovf_latched    = 1'b1;
				r.overflow_now = 1'b1;
				if (ovf_total != 32'hFFFF_FFFF)
					ovf_total++;
			end
		end

		r.next_deadline_us = NO_DEADLINE;
		if (wd_armed()) begin
			ivl = wd_interval();
			if (ivl != 0)
				r.next_deadline_us = TIME_W'(feed_us + ivl);
		end
		r.unlock_state   = key_phase;
		r.overflow_count = ovf_total;
		r.sys_clock_hz   = sys_hz;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Item builders
	// ------------------------------------------------------------------------
	function automatic tawd_in_t reg_write(input logic [7:0] addr, input logic [7:0] data,
			input logic [TIME_W-1:0] t);
		tawd_in_t w;
		w.func       = FUNC_WRITE;
		w.reg_addr   = addr;
		w.write_data = data;
		w.now_us     = t;
		return w;
	endfunction

	// Address and data of a poll carry no meaning, so they are random.
	function automatic tawd_in_t poll_at(input logic [TIME_W-1:0] t);
		tawd_in_t p;
		p.func       = FUNC_POLL;
		p.reg_addr   = 8'($urandom);
		p.write_data = 8'($urandom);
		p.now_us     = t;
		return p;
	endfunction

	// ------------------------------------------------------------------------
	// Handshake tasks. All of them are entered and left at a rising edge.
	// ------------------------------------------------------------------------

	// Offers one item, possibly after a random gap, and records its expected
	// result once the block has taken it.
	task automatic send_item(input tawd_in_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_results.push_back(predict_watchdog(it));
	endtask

	// Lets every outstanding result arrive, then gives the divider time to
	// finish any work that follows it.
	task automatic drain_block();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		drain_block();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		apply_register(idx, val);
	endtask

	task automatic unlock_at(input logic [TIME_W-1:0] t, input logic [TIME_W-1:0] gap);
		send_item(reg_write(ADDR_TA, KEY_FIRST, t));
		send_item(reg_write(ADDR_TA, KEY_SECOND, t + gap));
	endtask

	// ------------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------------
	function automatic void check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		tawd_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %p", $time, out_data);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("write_taken", want.write_taken, out_data.write_taken);
				check_field("unlock_state", want.unlock_state, out_data.unlock_state);
				check_field("overflow_now", want.overflow_now, out_data.overflow_now);
				check_field("overflow_count", want.overflow_count, out_data.overflow_count);
				check_field("next_deadline_us", want.next_deadline_us,
					out_data.next_deadline_us);
				check_field("sys_clock_hz", want.sys_clock_hz, out_data.sys_clock_hz);
			end
		end
	end

	// Output side: random stalls, or a long hold-off when one is requested.
	// The hold-off is counted here so that the sender keeps offering items
	// meanwhile and the block backs up into its input.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Key sequence: dropped write while locked, window edge, re-lock by a TA
	// write while open, stale first key, foreign-write abort, and a second
	// key stamped earlier than the first.
	task automatic test_unlock_sequence();
		send_item(reg_write(ADDR_CLKDIV, 8'h01, 48'd0));
		unlock_at(48'd10, 48'(WIN_RST));
		send_item(reg_write(ADDR_TA, KEY_FIRST, 48'd120));
		unlock_at(48'd200, 48'(WIN_RST) + 48'd1);
		send_item(reg_write(ADDR_TA, KEY_FIRST, 48'd400));
		send_item(reg_write(8'h00, 8'hFF, 48'd405));
		send_item(reg_write(ADDR_TA, KEY_FIRST, 48'd600));
		send_item(reg_write(ADDR_TA, KEY_SECOND, 48'd50));
		now_us = 48'd1000;
	endtask

	// Largest clock divider, arming, and polls one before and at the deadline.
	task automatic test_watchdog_overflow();
		logic [TIME_W-1:0] deadline;
		unlock_at(now_us, 48'd3);
		send_item(reg_write(ADDR_CLKDIV, 8'hFF, now_us + 48'd5));
		now_us = now_us + 48'd1000;
		unlock_at(now_us, 48'd1);
		send_item(reg_write(ADDR_WDCON, WDCON_ARM, now_us + 48'd2));
		deadline = TIME_W'(feed_us + wd_interval());
		send_item(poll_at(deadline - 48'd1));
		send_item(poll_at(deadline));
		now_us = deadline + 48'd10;
	endtask

	// Register extremes: no watchdog with the widest window, where a foreign
	// write no longer aborts and polls never fire; then the fastest
	// oscillator with a one-microsecond window and a deadline that wraps.
	task automatic test_register_extremes();
		write_register(CFG_WDT_PRESENT, '0);
		write_register(CFG_UNLOCK_WIN, CFG_DATA_W'(16'hFFFF));
		send_item(reg_write(ADDR_TA, KEY_FIRST, 48'd10000));
		send_item(reg_write(8'h80, 8'h5A, 48'd10001));
		send_item(reg_write(ADDR_TA, KEY_SECOND, 48'd10000 + 48'd65535));
		send_item(reg_write(ADDR_WDCON, WDCON_ARM | WDCON_FEED, 48'd80000));
		send_item(poll_at(48'h8000_0000_0000));

		write_register(CFG_OSC_FREQ, CFG_DATA_W'(OSC_MAX));
		write_register(CFG_WDT_PRESENT, CFG_DATA_W'(1));
		write_register(CFG_UNLOCK_WIN, CFG_DATA_W'(1));
		unlock_at(TIME_TOP - 48'd20, 48'd1);
		send_item(reg_write(ADDR_WDCON, WDCON_ARM | WDCON_FEED, TIME_TOP - 48'd10));
		send_item(poll_at(48'd3));
		now_us = 48'd100;
	endtask

	// Random traffic: mostly unlock sequences ending in a protected write and
	// polls close to the deadline, with scale changes, random polls and raw
	// noise mixed in.
	task automatic random_traffic(input int n_items);
		int                sent;
		int                pick;
		int                key_gap;
		logic [7:0]        target;
		logic [7:0]        val;
		longint unsigned   ivl;
		tawd_in_t          junk;

		sent = 0;
		while (sent < n_items) begin
			pick   = $urandom_range(99);
			now_us = now_us + $urandom_range(0, 40);
			if (pick < 30) begin
				if ($urandom_range(99) < 85)
					key_gap = $urandom_range(0, win_us);
				else
					key_gap = win_us + 1 + $urandom_range(0, 200);
				send_item(reg_write(ADDR_TA, KEY_FIRST, now_us));
				now_us = now_us + key_gap;
				send_item(reg_write(ADDR_TA,
					($urandom_range(9) == 0) ? 8'($urandom) : KEY_SECOND, now_us));
				target = $urandom_range(1) ? ADDR_WDCON : ADDR_CLKDIV;
				if (target == ADDR_CLKDIV)
					val = $urandom_range(1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
				else
					val = 8'($urandom) | (($urandom_range(9) < 7) ? WDCON_ARM : 8'h00);
				now_us = now_us + $urandom_range(0, 5);
				send_item(reg_write(target, val, now_us));
				sent += 3;
			end else if (pick < 55) begin
				ivl = wd_interval();
				if (wd_armed() && ivl != 0)
					now_us = TIME_W'(feed_us + ivl + $urandom_range(0, 6) - 3);
				send_item(poll_at(now_us));
				sent++;
			end else if (pick < 65) begin
				send_item(reg_write(ADDR_CKCON, 8'($urandom), now_us));
				sent++;
			end else if (pick < 75) begin
				now_us = now_us + $urandom_range(0, 100000);
				send_item(poll_at(now_us));
				sent++;
			end else begin
				junk.func       = 1'($urandom_range(1));
				junk.reg_addr   = 8'($urandom);
				junk.write_data = 8'($urandom);
				case ($urandom_range(7))
					0: junk.reg_addr = ADDR_TA;
					1: junk.reg_addr = ADDR_CLKDIV;
					2: junk.reg_addr = ADDR_WDCON;
					default: ;
				endcase
				if ($urandom_range(4) == 0)
					junk.now_us = 48'({$urandom, $urandom});
				else
					junk.now_us = now_us;
				now_us = junk.now_us;
				send_item(junk);
				sent++;
			end
		end
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
			input logic [FREQ_W-1:0] osc, input logic wdt, input logic [WIN_W-1:0] win,
			input int n_items);
		write_register(CFG_OSC_FREQ, CFG_DATA_W'(osc));
		write_register(CFG_WDT_PRESENT, CFG_DATA_W'(wdt));
		write_register(CFG_UNLOCK_WIN, CFG_DATA_W'(win));
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		random_traffic(n_items);
	endtask

	// The output side holds off for a long stretch while items keep coming,
	// so the block fills and drops in_ready.
	task automatic test_backpressure();
		drain_block();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b1;
		random_traffic(30);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_data        = '0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		out_ready      = 1'b0;
		error_count    = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b0;
		hold_left      = 0;
		now_us         = '0;
		reset_watchdog_model();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unlock_sequence();
		test_watchdog_overflow();
		test_register_extremes();
		test_random_traffic(0, 0, OSC_RST, 1'b1, WIN_RST, 120);
		test_backpressure();
		test_random_traffic(55, 0, FREQ_W'(1), 1'b1, WIN_W'(1), 120);
		test_random_traffic(0, 55, OSC_MAX, 1'b0, WIN_W'(16'hFFFF), 120);
		test_random_traffic(16, 16, FREQ_W'($urandom_range(1, 33554431)), 1'b1,
			WIN_W'($urandom_range(1, 65535)), 120);

		drain_block();
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ timed_access_watchdog_unit.f @@
+incdir+rtl
rtl/tawd_pkg.sv
rtl/tawd_div.sv
rtl/tawd_dp.sv
rtl/tawd_ctrl.sv
rtl/timed_access_watchdog_unit.sv
bench/tb_timed_access_watchdog_unit.sv
